// ----- rtl/core/normalized_heat_colormap_core_macros.svh -----
// Assertion macros shared by the colormap core modules.
`ifndef NORMALIZED_HEAT_COLORMAP_CORE_MACROS_SVH
`define NORMALIZED_HEAT_COLORMAP_CORE_MACROS_SVH
`ifndef SYNTH
`define NHC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("colormap core assertion failed");
`define NHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("colormap core assertion failed");
`else
`define NHC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NHC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/nhc_pkg.sv -----
// Types and constants of the colormap core.
`default_nettype none
package nhc_pkg;

   localparam int SAMPLE_BITS = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int DIFF_BITS = SAMPLE_BITS;
   localparam int COLOR_BITS = 8;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef enum logic [0:0] {
      CSR_RANGE_LOW  = 1'b0,
      CSR_RANGE_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SEG_BLUE_CYAN    = 2'd0,
      SEG_CYAN_GREEN   = 2'd1,
      SEG_GREEN_YELLOW = 2'd2,
      SEG_YELLOW_RED   = 2'd3
   } seg_type;

   localparam sample_type RANGE_LOW_RESET  = 32'sd0;
   localparam sample_type RANGE_HIGH_RESET = 32'sd65535;
   localparam color_type COLOR_FULL = 8'd255;
   localparam color_type COLOR_NONE = 8'd0;

   typedef struct packed {
      logic                 white;
      logic                 forced;
      logic                 forced_one;
      logic [DIFF_BITS-1:0] rem;
      logic [DIFF_BITS-1:0] den;
   } div_state_type;

endpackage
`default_nettype wire

// ----- rtl/core/nhc_intf.sv -----
// Channel interfaces of the colormap core: sample, pixel and register write.
`default_nettype none
interface nhc_req_if;
   import nhc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       sample_invalid;
   modport source (output valid, output sample, output sample_invalid, input ready);
   modport sink (input valid, input sample, input sample_invalid, output ready);
endinterface

interface nhc_rsp_if;
   import nhc_pkg::*;
   logic      valid;
   logic      ready;
   color_type red;
   color_type green;
   color_type blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface nhc_csr_if;
   import nhc_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/nhc_prep.sv -----
// Front stage: range checks, special cases and dividend/divisor setup.
`default_nettype none
module nhc_prep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  nhc_pkg::sample_type    sample,
   input  logic                   sample_invalid,
   input  nhc_pkg::sample_type    range_low,
   input  nhc_pkg::sample_type    range_high,
   output logic                   out_valid,
   input  logic                   out_ready,
   output nhc_pkg::div_state_type out_state
);
   import nhc_pkg::*;

   logic signed [SAMPLE_BITS:0] s_x;
   logic signed [SAMPLE_BITS:0] lo_x;
   logic signed [SAMPLE_BITS:0] hi_x;
   logic [SAMPLE_BITS:0]        num_x;
   logic [SAMPLE_BITS:0]        den_x;
   logic                        empty;
   logic                        above_lo;
   logic                        at_hi;
   div_state_type               state_in;
   div_state_type               state_ff;
   logic                        valid_ff;

   assign s_x   = {sample[SAMPLE_BITS-1], sample};
   assign lo_x  = {range_low[SAMPLE_BITS-1], range_low};
   assign hi_x  = {range_high[SAMPLE_BITS-1], range_high};
   assign num_x = s_x - lo_x;
   assign den_x = hi_x - lo_x;
   assign empty    = !(hi_x > lo_x);
   assign above_lo = s_x > lo_x;
   assign at_hi    = s_x >= hi_x;

   always_comb begin
      state_in.white      = sample_invalid;
      state_in.forced     = 1'b1;
      state_in.forced_one = 1'b0;
      if (sample_invalid) begin
         state_in.forced_one = 1'b0;
      end else if (empty) begin
         state_in.forced_one = above_lo;
      end else if (!above_lo) begin
         state_in.forced_one = 1'b0;
      end else if (at_hi) begin
         state_in.forced_one = 1'b1;
      end else begin
         state_in.forced = 1'b0;
      end
      state_in.rem = state_in.forced ? '0 : num_x[DIFF_BITS-1:0];
      state_in.den = state_in.forced ? DIFF_BITS'(1) : den_x[DIFF_BITS-1:0];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule
`default_nettype wire

// ----- rtl/core/nhc_div_step.sv -----
// One restoring division step: one quotient bit per register stage.
`default_nettype none
`include "normalized_heat_colormap_core_macros.svh"
module nhc_div_step #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  nhc_pkg::div_state_type in_state,
   input  logic [FRAC_BITS-1:0]   in_quot,
   output logic                   out_valid,
   input  logic                   out_ready,
   output nhc_pkg::div_state_type out_state,
   output logic [FRAC_BITS-1:0]   out_quot
);
   import nhc_pkg::*;

   logic [DIFF_BITS:0]     rem2;
   logic [DIFF_BITS:0]     den_x;
   logic [DIFF_BITS:0]     diff;
   logic                   take;
   div_state_type          state_in;
   logic [FRAC_BITS-1:0]   quot_in;
   div_state_type          state_ff;
   logic [FRAC_BITS-1:0]   quot_ff;
   logic                   valid_ff;

   assign rem2  = {in_state.rem, 1'b0};
   assign den_x = {1'b0, in_state.den};
   assign diff  = rem2 - den_x;
   assign take  = rem2 >= den_x;

   always_comb begin
      state_in     = in_state;
      state_in.rem = take ? diff[DIFF_BITS-1:0] : rem2[DIFF_BITS-1:0];
      quot_in      = {in_quot[FRAC_BITS-2:0], take};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         state_ff <= state_in;
         quot_ff  <= quot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_quot  = quot_ff;

   `NHC_ASSERT_IMPLY(a_rem_below_den, clock, reset, valid_ff, state_ff.rem < state_ff.den)
   `NHC_ASSERT_NEXT(a_accept_fills, clock, reset, in_valid && in_ready, valid_ff)

endmodule
`default_nettype wire

// ----- rtl/core/nhc_shade.sv -----
// Segment split and channel blend, two register stages ending in the pixel register.
`default_nettype none
`include "normalized_heat_colormap_core_macros.svh"
module nhc_shade #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  nhc_pkg::div_state_type in_state,
   input  logic [FRAC_BITS-1:0]   in_quot,
   output logic                   out_valid,
   input  logic                   out_ready,
   output nhc_pkg::color_type     red,
   output nhc_pkg::color_type     green,
   output nhc_pkg::color_type     blue
);
   import nhc_pkg::*;

   localparam int SEG_SHIFT = FRAC_BITS - 2;
   localparam int PROD_BITS = SEG_SHIFT + COLOR_BITS + 1;
   localparam logic [SEG_SHIFT:0] SEG_LEN = {1'b1, {SEG_SHIFT{1'b0}}};
   localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(SEG_LEN >> 1);

   function automatic color_type scale(input logic [SEG_SHIFT:0] x);
      logic [PROD_BITS-1:0] xe;
      logic [PROD_BITS-1:0] prod;
      xe   = PROD_BITS'(x);
      prod = (xe << COLOR_BITS) - xe + HALF;
      return prod[SEG_SHIFT +: COLOR_BITS];
   endfunction

   logic [FRAC_BITS:0] t_full;
   seg_type            seg_in;
   logic [SEG_SHIFT:0] loc_in;
   logic [SEG_SHIFT:0] down_in;

   logic               a_valid_ff;
   logic               a_white_ff;
   seg_type            a_seg_ff;
   logic [SEG_SHIFT:0] a_up_ff;
   logic [SEG_SHIFT:0] a_down_ff;
   logic               a_ready;

   color_type          up_c;
   color_type          down_c;
   color_type          red_in;
   color_type          green_in;
   color_type          blue_in;
   logic               b_valid_ff;
   logic               b_white_ff;
   color_type          red_ff;
   color_type          green_ff;
   color_type          blue_ff;
   logic               b_ready;

   always_comb begin
      if (in_state.forced) begin
         t_full = in_state.forced_one ? T_ONE : '0;
      end else begin
         t_full = {1'b0, in_quot};
      end
      if (t_full[FRAC_BITS]) begin
         seg_in = SEG_YELLOW_RED;
         loc_in = SEG_LEN;
      end else begin
         seg_in = seg_type'(t_full[FRAC_BITS-1 -: 2]);
         loc_in = {1'b0, t_full[SEG_SHIFT-1:0]};
      end
      down_in = SEG_LEN - loc_in;
   end

   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         a_white_ff <= in_state.white;
         a_seg_ff   <= seg_in;
         a_up_ff    <= loc_in;
         a_down_ff  <= down_in;
      end
   end

   assign up_c   = scale(a_up_ff);
   assign down_c = scale(a_down_ff);

   always_comb begin
      case (a_seg_ff)
         SEG_BLUE_CYAN: begin
            red_in = COLOR_NONE; green_in = up_c; blue_in = COLOR_FULL;
         end
         SEG_CYAN_GREEN: begin
            red_in = COLOR_NONE; green_in = COLOR_FULL; blue_in = down_c;
         end
         SEG_GREEN_YELLOW: begin
            red_in = up_c; green_in = COLOR_FULL; blue_in = COLOR_NONE;
         end
         default: begin
            red_in = COLOR_FULL; green_in = down_c; blue_in = COLOR_NONE;
         end
      endcase
      if (a_white_ff) begin
         red_in   = COLOR_FULL;
         green_in = COLOR_FULL;
         blue_in  = COLOR_FULL;
      end
   end

   assign b_ready = !b_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && b_ready) begin
         b_white_ff <= a_white_ff;
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

   `NHC_ASSERT_IMPLY(a_one_channel_full, clock, reset, b_valid_ff,
                     red_ff == COLOR_FULL || green_ff == COLOR_FULL || blue_ff == COLOR_FULL)
   `NHC_ASSERT_IMPLY(a_one_channel_dark, clock, reset, b_valid_ff && !b_white_ff,
                     red_ff == COLOR_NONE || blue_ff == COLOR_NONE)

endmodule
`default_nettype wire

// ----- rtl/core/normalized_heat_colormap_core.sv -----
// Top level of the normalized heat colormap core.
`default_nettype none
// Maps one signed sample per beat to a blue-cyan-green-yellow-red pixel; an
// invalid sample gives white. The position t = (sample - range_low) /
// (range_high - range_low), clamped to 0..1, is a truncated fraction of
// FRAC_BITS bits, found by a restoring divider that settles one quotient bit
// per register stage. A new sample is taken every cycle while the output is
// not stalled; the pipeline is a front stage, FRAC_BITS divider stages and
// two blend stages. An empty or inverted range gives red for samples above
// range_low and blue otherwise. Write range_low and range_high only while no
// beat is in flight.
module normalized_heat_colormap_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic   clock,
   input  logic   reset,
   nhc_req_if.sink   req_if,
   nhc_rsp_if.source rsp_if,
   nhc_csr_if.sink   csr_if
);
   import nhc_pkg::*;

   sample_type    range_low_ff;
   sample_type    range_high_ff;

   logic          valid_chain [FRAC_BITS+1];
   logic          ready_chain [FRAC_BITS+1];
   div_state_type state_chain [FRAC_BITS+1];
   logic [FRAC_BITS-1:0] quot_chain [FRAC_BITS+1];

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_RANGE_LOW:  range_low_ff  <= sample_type'(csr_if.data);
            CSR_RANGE_HIGH: range_high_ff <= sample_type'(csr_if.data);
         endcase
      end
   end

   nhc_prep u_prep (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_if.valid),
      .in_ready       (req_if.ready),
      .sample         (req_if.sample),
      .sample_invalid (req_if.sample_invalid),
      .range_low      (range_low_ff),
      .range_high     (range_high_ff),
      .out_valid      (valid_chain[0]),
      .out_ready      (ready_chain[0]),
      .out_state      (state_chain[0])
   );

   assign quot_chain[0] = '0;

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
      nhc_div_step #(
         .FRAC_BITS (FRAC_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[k]),
         .in_ready  (ready_chain[k]),
         .in_state  (state_chain[k]),
         .in_quot   (quot_chain[k]),
         .out_valid (valid_chain[k+1]),
         .out_ready (ready_chain[k+1]),
         .out_state (state_chain[k+1]),
         .out_quot  (quot_chain[k+1])
      );
   end

   nhc_shade #(
      .FRAC_BITS (FRAC_BITS)
   ) u_shade (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_chain[FRAC_BITS]),
      .in_ready  (ready_chain[FRAC_BITS]),
      .in_state  (state_chain[FRAC_BITS]),
      .in_quot   (quot_chain[FRAC_BITS]),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .red       (rsp_if.red),
      .green     (rsp_if.green),
      .blue      (rsp_if.blue)
   );

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench of the heat colormap core: directed table, then random range phases vs. a predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nhc_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int SEG_SHIFT = FRAC_BITS - 2;
   localparam longint unsigned T_ONE = 64'd1 << FRAC_BITS;
   localparam longint unsigned SEG_LEN = 64'd1 << SEG_SHIFT;
   localparam int CLK_PERIOD = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_COUNT = 11;
   localparam int PHASE_BEATS = 100;

   typedef struct packed {
      color_type red;
      color_type green;
      color_type blue;
   } pixel_type;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_RANGE
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  a;
      logic [31:0]  b;
      logic         invalid;
      logic         known;
      pixel_type    px;
   } dir_row_type;

   localparam pixel_type NO_PX     = '0;
   localparam pixel_type BLUE_PX   = '{COLOR_NONE, COLOR_NONE, COLOR_FULL};
   localparam pixel_type CYAN_PX   = '{COLOR_NONE, COLOR_FULL, COLOR_FULL};
   localparam pixel_type GREEN_PX  = '{COLOR_NONE, COLOR_FULL, COLOR_NONE};
   localparam pixel_type YELLOW_PX = '{COLOR_FULL, COLOR_FULL, COLOR_NONE};
   localparam pixel_type RED_PX    = '{COLOR_FULL, COLOR_NONE, COLOR_NONE};
   localparam pixel_type WHITE_PX  = '{COLOR_FULL, COLOR_FULL, COLOR_FULL};

   localparam int DIR_ROWS = 30;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{ROW_SAMPLE, 32'd0,          32'd0,          1'b0, 1'b1, BLUE_PX},
      '{ROW_SAMPLE, 32'd65535,      32'd0,          1'b0, 1'b1, RED_PX},
      '{ROW_SAMPLE, 32'h8000_0000,  32'd0,          1'b0, 1'b1, BLUE_PX},
      '{ROW_SAMPLE, 32'h7FFF_FFFF,  32'd0,          1'b0, 1'b1, RED_PX},
      '{ROW_SAMPLE, 32'hFFFF_FFFF,  32'd0,          1'b0, 1'b1, BLUE_PX},
      '{ROW_SAMPLE, 32'd0,          32'd0,          1'b1, 1'b1, WHITE_PX},
      '{ROW_SAMPLE, 32'hFFFF_FFFF,  32'd0,          1'b1, 1'b1, WHITE_PX},
      '{ROW_SAMPLE, 32'd12345,      32'd0,          1'b0, 1'b0, NO_PX},
      '{ROW_RANGE,  32'd0,          32'd65536,      1'b0, 1'b0, NO_PX},
      '{ROW_SAMPLE, 32'd16384,      32'd0,          1'b0, 1'b1, CYAN_PX},
      '{ROW_SAMPLE, 32'd32768,      32'd0,          1'b0, 1'b1, GREEN_PX},
      '{ROW_SAMPLE, 32'd49152,      32'd0,          1'b0, 1'b1, YELLOW_PX},
      '{ROW_SAMPLE, 32'd65536,      32'd0,          1'b0, 1'b1, RED_PX},
      '{ROW_SAMPLE, 32'd8192,       32'd0,          1'b0, 1'b0, NO_PX},
      '{ROW_SAMPLE, 32'd57344,      32'd0,          1'b0, 1'b0, NO_PX},
      '{ROW_RANGE,  32'd100,        32'd100,        1'b0, 1'b0, NO_PX},
      '{ROW_SAMPLE, 32'd101,        32'd0,          1'b0, 1'b1, RED_PX},
      '{ROW_SAMPLE, 32'd100,        32'd0,          1'b0, 1'b1, BLUE_PX},
      '{ROW_RANGE,  32'h7FFF_FFFF,  32'h8000_0000,  1'b0, 1'b0, NO_PX},
      '{ROW_SAMPLE, 32'h7FFF_FFFF,  32'd0,          1'b0, 1'b1, BLUE_PX},
      '{ROW_SAMPLE, 32'h8000_0000,  32'd0,          1'b0, 1'b1, BLUE_PX},
      '{ROW_RANGE,  32'h8000_0000,  32'h7FFF_FFFF,  1'b0, 1'b0, NO_PX},
      '{ROW_SAMPLE, 32'h8000_0000,  32'd0,          1'b0, 1'b1, BLUE_PX},
      '{ROW_SAMPLE, 32'h7FFF_FFFF,  32'd0,          1'b0, 1'b1, RED_PX},
      '{ROW_SAMPLE, 32'd0,          32'd0,          1'b0, 1'b0, NO_PX},
      '{ROW_SAMPLE, 32'h5555_5555,  32'd0,          1'b1, 1'b1, WHITE_PX},
      '{ROW_RANGE,  -32'sd1000,     32'd1000,       1'b0, 1'b0, NO_PX},
      '{ROW_SAMPLE, -32'sd1000,     32'd0,          1'b0, 1'b1, BLUE_PX},
      '{ROW_SAMPLE, 32'd1000,       32'd0,          1'b0, 1'b1, RED_PX},
      '{ROW_SAMPLE, 32'd1,          32'd0,          1'b0, 1'b0, NO_PX}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   nhc_req_if req_bus ();
   nhc_rsp_if rsp_bus ();
   nhc_csr_if csr_bus ();

   normalized_heat_colormap_core #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_if(csr_bus)
   );

   sample_type cfg_low = RANGE_LOW_RESET;
   sample_type cfg_high = RANGE_HIGH_RESET;
   pixel_type pixel_q [$];
   int error_count = 0;
   int cycle_count = 0;
   int rsp_hold_left = 0;
   bit idle_on = 1'b1;

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic color_type ramp(input longint unsigned x);
      return color_type'((255 * x + SEG_LEN / 2) >> SEG_SHIFT);
   endfunction

   function automatic pixel_type heat_pixel(input sample_type s, input logic inv,
                                            input sample_type lo, input sample_type hi);
      longint sv, lv, hv;
      longint unsigned num, den, pos, loc;
      seg_type seg;
      pixel_type px;
      sv = s;
      lv = lo;
      hv = hi;
      if (hv <= lv) begin
         pos = (sv > lv) ? T_ONE : 64'd0;
      end else if (sv <= lv) begin
         pos = 0;
      end else if (sv >= hv) begin
         pos = T_ONE;
      end else begin
         num = sv - lv;
         den = hv - lv;
         pos = (num << FRAC_BITS) / den;
      end
      if ((pos >> SEG_SHIFT) > 3) begin
         seg = SEG_YELLOW_RED;
         loc = SEG_LEN;
      end else begin
         seg = seg_type'(pos >> SEG_SHIFT);
         loc = pos & (SEG_LEN - 1);
      end
      case (seg)
         SEG_BLUE_CYAN: begin
            px = '{COLOR_NONE, ramp(loc), COLOR_FULL};
         end
         SEG_CYAN_GREEN: begin
            px = '{COLOR_NONE, COLOR_FULL, ramp(SEG_LEN - loc)};
         end
         SEG_GREEN_YELLOW: begin
            px = '{ramp(loc), COLOR_FULL, COLOR_NONE};
         end
         default: begin
            px = '{COLOR_FULL, ramp(SEG_LEN - loc), COLOR_NONE};
         end
      endcase
      if (inv) begin
         px = WHITE_PX;
      end
      return px;
   endfunction

   function automatic sample_type pick_sample();
      longint lv, hv, v;
      int pick;
      lv = cfg_low;
      hv = cfg_high;
      pick = $urandom_range(99);
      if (pick < 60 && hv > lv) begin
         v = lv + longint'($urandom_range(int'(hv - lv), 0));
      end else if (pick < 80) begin
         v = (pick[0] ? lv : hv) + longint'($urandom_range(6)) - 3;
      end else if (pick < 95) begin
         v = longint'($urandom);
      end else begin
         v = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
      end
      return sample_type'(v);
   endfunction

   task automatic push_sample(input sample_type s, input logic inv, input pixel_type px);
      if (idle_on && $urandom_range(99) < 18) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample <= s;
      req_bus.sample_invalid <= inv;
      do @(posedge clock); while (!req_bus.ready);
      pixel_q.push_back(px);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_range(input sample_type lo, input sample_type hi);
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_RANGE_LOW;
      csr_bus.data <= lo;
      do @(posedge clock); while (!csr_bus.ready);
      cfg_low = lo;
      csr_bus.index <= CSR_RANGE_HIGH;
      csr_bus.data <= hi;
      do @(posedge clock); while (!csr_bus.ready);
      cfg_high = hi;
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      pixel_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pixel_q.size() == 0) begin
               $error("rsp beat with no pixel expected");
               error_count++;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_bus.red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, rsp_bus.red);
                  error_count++;
               end
               if (rsp_bus.green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, rsp_bus.green);
                  error_count++;
               end
               if (rsp_bus.blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, rsp_bus.blue);
                  error_count++;
               end
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !(idle_on && $urandom_range(99) < 26);
         end
      end
   end

   initial begin
      dir_row_type row;
      sample_type s, lo, hi;
      longint lo_l;
      logic inv;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      req_bus.sample_invalid = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_RANGE_LOW;
      csr_bus.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_RANGE) begin
            write_range(row.a, row.b);
         end else begin
            push_sample(row.a, row.invalid,
                        row.known ? row.px : heat_pixel(row.a, row.invalid, cfg_low, cfg_high));
         end
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph % 6)
            0: begin
               lo = RANGE_LOW_RESET;
               hi = RANGE_HIGH_RESET;
            end
            1: begin
               lo = 32'h8000_0000;
               hi = 32'h7FFF_FFFF;
            end
            2: begin
               lo = 32'h7FFF_FFFF;
               hi = 32'h8000_0000;
            end
            3: begin
               lo = $urandom;
               hi = lo;
            end
            4: begin
               lo = $urandom;
               lo_l = lo;
               if (lo_l > 64'sd2147483600) begin
                  lo_l -= 64;
               end
               lo = sample_type'(lo_l);
               hi = sample_type'(lo_l + longint'($urandom_range(40, 1)));
            end
            default: begin
               lo = $urandom;
               hi = $urandom;
            end
         endcase
         write_range(lo, hi);
         idle_on = (ph != 5);
         for (int k = 0; k < PHASE_BEATS; k++) begin
            if (ph == 7 && k == 20) begin
               rsp_hold_left = 150;
            end
            s = pick_sample();
            inv = ($urandom_range(99) < 6);
            push_sample(s, inv, heat_pixel(s, inv, cfg_low, cfg_high));
         end
      end

      wait_drained();
      repeat (FRAC_BITS + 8) @(posedge clock);
      if (pixel_q.size() != 0) begin
         $error("%0d pixels never arrived", pixel_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
